// File: design/rmck_pkg.sv
// ----------------------------------------------------------------------------
// rmck_pkg
// Shared types and constants of the RGBA to mask-format converter.
// ----------------------------------------------------------------------------
package rmck_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ShiftW = 5;   // bit position 0..31
  localparam int unsigned WidthW = 6;   // run length 0..32
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegRedMask   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGreenMask = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlueMask  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAlphaMask = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWide      = 3'd4;

  // alpha at or above this is opaque
  localparam logic [ChanW-1:0] AlphaOpaqueMin = 8'd128;

  // one channel's mask with its decoded field position and length
  typedef struct packed {
    logic [PixW-1:0]   mask;
    logic [ShiftW-1:0] shift;
    logic [WidthW-1:0] width;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
    logic [PixW-1:0] alpha_mask;
    logic            wide;
  } fmt_cfg_t;

endpackage

// File: design/rgba_to_mask_format_color_key.sv
// ----------------------------------------------------------------------------
// rgba_to_mask_format_color_key
// RGBA8888 pixel to mask-defined surface pixel with transparency color key.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall_o is low. A pixel accepted at a
// clock edge is held in the input register; the channel placement and key
// logic then fill the result register, which presents the packed pixel. The
// input register refills when it is empty or the result moves on, so a new
// pixel is taken while a result waits only into an empty input register.
// Masks are decoded into shift and width when written; write them only while
// no pixel is in flight. Pixels with alpha below 128 become green_mask |
// alpha_mask. An opaque pixel that matches that key gets the green field's
// value for one flipped: the lowest green bit for an 8-bit field, a higher
// one for wider fields, and nothing when green is narrower than 8 bits.
module rgba_to_mask_format_color_key (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmck_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmck_pkg::PixW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rmck_pkg::ChanW-1:0]    red_in_i,
  input  logic [rmck_pkg::ChanW-1:0]    green_in_i,
  input  logic [rmck_pkg::ChanW-1:0]    blue_in_i,
  input  logic [rmck_pkg::ChanW-1:0]    alpha_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rmck_pkg::PixW-1:0]     pixel_out_o
);

  rmck_pkg::fmt_cfg_t cfg;

  logic                         s1_valid_q;
  logic [rmck_pkg::ChanW-1:0]   red_q, green_q, blue_q, alpha_q;
  logic                         out_valid_q;
  logic [rmck_pkg::PixW-1:0]    pixel_q, pixel_d;
  logic                         s1_ready, s2_ready, s1_load;

  logic [rmck_pkg::PixW-1:0]    red_f, green_f, blue_f, green_one;
  logic [rmck_pkg::PixW-1:0]    key, opaque, full;

  rmck_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rmck_place u_place_red   (.value_i(red_q),   .chan_i(cfg.red),   .field_o(red_f));
  rmck_place u_place_green (.value_i(green_q), .chan_i(cfg.green), .field_o(green_f));
  rmck_place u_place_blue  (.value_i(blue_q),  .chan_i(cfg.blue),  .field_o(blue_f));
  rmck_place u_place_glsb  (.value_i(8'd1),    .chan_i(cfg.green), .field_o(green_one));

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_load    = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_comb begin
    key    = cfg.green.mask | cfg.alpha_mask;
    opaque = red_f | green_f | blue_f | cfg.alpha_mask;
    if (alpha_q < rmck_pkg::AlphaOpaqueMin) begin
      full = key;
    end else if (opaque == key) begin
      full = opaque ^ green_one;
    end else begin
      full = opaque;
    end
    pixel_d = cfg.wide ? full : {16'd0, full[15:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      alpha_q <= alpha_in_i;
    end
    // hold the result while the consumer stalls
    if (s2_ready && s1_valid_q) pixel_q <= pixel_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q)
    else $error("input stage dropped a pixel under stall");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input stage");

  a_key_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready && alpha_q < rmck_pkg::AlphaOpaqueMin && cfg.wide
    |=> pixel_out_o == $past(key))
    else $error("transparent pixel did not produce the key");

  a_narrow_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready && !cfg.wide |=> pixel_out_o[31:16] == 16'd0)
    else $error("upper half set in 2-byte mode");
`endif

endmodule

// File: design/rmck_cfg.sv
// ----------------------------------------------------------------------------
// rmck_cfg
// Format registers; decodes each channel mask into shift and width on write.
// ----------------------------------------------------------------------------
module rmck_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmck_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmck_pkg::PixW-1:0]     cfg_wdata_i,
  output rmck_pkg::fmt_cfg_t            cfg_o
);

  rmck_pkg::chan_cfg_t red_q, green_q, blue_q, wr_chan;
  logic [rmck_pkg::PixW-1:0] alpha_q;
  logic                      wide_q;

  logic [rmck_pkg::PixW-1:0] lsb_oh;
  logic [rmck_pkg::PixW-1:0] run;
  logic [rmck_pkg::PixW:0]   run_ext;
  logic [rmck_pkg::PixW:0]   end_oh;
  logic [rmck_pkg::ShiftW-1:0] shift;
  logic [rmck_pkg::WidthW-1:0] width;

  // lowest set bit gives the shift; the first zero above it ends the run
  always_comb begin
    lsb_oh = cfg_wdata_i & (~cfg_wdata_i + 32'd1);
    shift  = '0;
    for (int i = 0; i < rmck_pkg::PixW; i++) begin
      if (lsb_oh[i]) shift = shift | rmck_pkg::ShiftW'(i);
    end
    run     = cfg_wdata_i >> shift;
    run_ext = {1'b0, run};
    end_oh  = ~run_ext & (run_ext + 33'd1);
    width   = '0;
    for (int i = 0; i <= rmck_pkg::PixW; i++) begin
      if (end_oh[i]) width = width | rmck_pkg::WidthW'(i);
    end
    wr_chan.mask  = cfg_wdata_i;
    wr_chan.shift = shift;
    wr_chan.width = width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '{mask: 32'h00FF_0000, shift: 5'd16, width: 6'd8};
      green_q <= '{mask: 32'h0000_FF00, shift: 5'd8,  width: 6'd8};
      blue_q  <= '{mask: 32'h0000_00FF, shift: 5'd0,  width: 6'd8};
      alpha_q <= 32'hFF00_0000;
      wide_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rmck_pkg::RegRedMask:   red_q   <= wr_chan;
        rmck_pkg::RegGreenMask: green_q <= wr_chan;
        rmck_pkg::RegBlueMask:  blue_q  <= wr_chan;
        rmck_pkg::RegAlphaMask: alpha_q <= cfg_wdata_i;
        rmck_pkg::RegWide:      wide_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.red        = red_q;
  assign cfg_o.green      = green_q;
  assign cfg_o.blue       = blue_q;
  assign cfg_o.alpha_mask = alpha_q;
  assign cfg_o.wide       = wide_q;

endmodule

// File: design/rmck_place.sv
// ----------------------------------------------------------------------------
// rmck_place
// Scales one 8-bit channel to its field width and places it under its mask.
// ----------------------------------------------------------------------------
module rmck_place (
  input  logic [rmck_pkg::ChanW-1:0] value_i,
  input  rmck_pkg::chan_cfg_t        chan_i,
  output logic [rmck_pkg::PixW-1:0]  field_o
);

  logic [2*rmck_pkg::PixW-1:0] wide_v;
  logic [rmck_pkg::PixW-1:0]   narrow_v;
  logic [rmck_pkg::PixW-1:0]   placed;
  logic [6:0]                  up_amt;
  logic [3:0]                  down_amt;

  always_comb begin
    up_amt   = 7'(chan_i.width) - 7'd8 + 7'(chan_i.shift);
    down_amt = 4'd8 - {1'b0, chan_i.width[2:0]};
    wide_v   = {56'd0, value_i} << up_amt;
    narrow_v = {24'd0, value_i >> down_amt} << chan_i.shift;
    // fields of 8 bits or more widen by left shift, narrower ones truncate
    if (chan_i.width >= 6'd8) begin
      placed = wide_v[rmck_pkg::PixW-1:0];
    end else begin
      placed = narrow_v;
    end
    field_o = placed & chan_i.mask;
  end

endmodule
